// ----- hdl/corot_pkg.sv -----
// Shared constants, tables and types for the camera orbit rotation core.
// No dependencies; used by corot_unitize, corot_trig and the top level.
package corot_pkg;

	localparam int VW         = 24;
	localparam int AW         = 16;
	localparam int QB         = 30;
	localparam int IN_DW      = AW + 6 * VW;
	localparam int OUT_DW     = 6 * VW;

	// unit vector scaling
	localparam int UW         = 2 * VW + 1;
	localparam int RSH_MAX    = UW - QB;
	localparam int RSH_W      = $clog2(RSH_MAX + 1);
	localparam int WS_W       = QB + 1;
	localparam int MAG_W      = QB;
	localparam int LSH_W      = $clog2(QB);
	localparam int SQ_W       = 2 * QB + 2;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int SQ_REM_W   = ROOT_W + 2;
	localparam int DVD_W      = 2 * QB + 1;
	localparam int DIV_STEPS  = 32;
	localparam int UNIT_OW    = DIV_STEPS;
	localparam int UNIT_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	// sine / cosine
	localparam int TRIG_ITERATIONS = 18;
	localparam int TRIG_LAT   = 5 + TRIG_ITERATIONS;
	localparam int CW         = 34;
	localparam int AMAG_W     = 13;
	localparam int ANG_FULL   = 23040;
	localparam int ANG_HALF   = 11520;
	localparam int ANG_QUARTER = 5760;
	localparam logic [18:0] PI_QUO  = 19'd292817;
	localparam logic [12:0] PI_REM  = 13'd7586;
	localparam logic [18:0] RECIP45 = 19'd372828;
	localparam int PRE_SH     = 8;
	localparam int RECIP_SH   = 24;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	localparam logic signed [VW-1:0] OUT_MAX = 24'sd8388607;
	localparam logic signed [VW-1:0] OUT_MIN = -24'sd8388608;

	typedef logic signed [VW-1:0] vec_t;

endpackage

// ----- hdl/corot_unitize.sv -----
// Pipelined unit vector scaling: power-of-two prescale, integer square root
// and rounded division, one bit per stage. Depends on corot_pkg.
module corot_unitize (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_in,
	input  logic signed [corot_pkg::UW-1:0]       w_in [3],
	output logic                                  vld_out,
	output logic                                  zero_out,
	output logic signed [corot_pkg::UNIT_OW-1:0]  u_out [3]
);
	import corot_pkg::*;

	typedef struct packed {
		logic                  vld;
		logic                  zero;
		logic [2:0]            sgn;
		logic [2:0][MAG_W-1:0] mag;
	} side_t;

	// prescale search
	logic signed [UW-1:0]   w_s1 [3];
	logic [RSH_MAX:0]       fit_s1;
	logic                   vld_s1;
	logic                   zero_s1;
	logic [RSH_MAX:0]       fit_c;

	always_comb begin
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		for (int k = 0; k <= RSH_MAX; k++) begin
			hi = 64'sd1 <<< (QB + k);
			lo = -(((64'sd1 <<< QB) - 64'sd1) <<< k);
			fit_c[k] = 1'b1;
			for (int i = 0; i < 3; i++)
				if (64'(w_in[i]) >= hi || 64'(w_in[i]) < lo)
					fit_c[k] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= w_in;
			fit_s1  <= fit_c;
			zero_s1 <= (w_in[0] == '0) && (w_in[1] == '0) && (w_in[2] == '0);
		end
	end

	// right shift
	logic [RSH_W-1:0]       ksel;
	logic signed [WS_W-1:0] ws_c [3];
	logic signed [WS_W-1:0] ws_s2 [3];
	logic                   vld_s2;
	logic                   zero_s2;

	always_comb begin
		ksel = '0;
		for (int k = RSH_MAX; k >= 0; k--)
			if (fit_s1[k])
				ksel = RSH_W'(k);
		for (int i = 0; i < 3; i++)
			ws_c[i] = WS_W'(w_s1[i] >>> ksel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ws_s2   <= ws_c;
			zero_s2 <= zero_s1;
		end
	end

	// magnitudes and left shift count
	side_t            side_c3;
	logic [MAG_W-1:0] orv;
	logic [LSH_W-1:0] lsh_c;
	side_t            side_s3;
	logic [LSH_W-1:0] lsh_s3;

	always_comb begin
		side_c3.vld  = vld_s2;
		side_c3.zero = zero_s2;
		for (int i = 0; i < 3; i++) begin
			side_c3.sgn[i] = ws_s2[i][WS_W-1];
			side_c3.mag[i] = ws_s2[i][WS_W-1] ? MAG_W'(-ws_s2[i]) : MAG_W'(ws_s2[i]);
		end
		orv   = side_c3.mag[0] | side_c3.mag[1] | side_c3.mag[2];
		lsh_c = '0;
		for (int b = 0; b < MAG_W; b++)
			if (orv[b])
				lsh_c = LSH_W'(MAG_W - 1 - b);
	end

	side_t                side_c4;
	side_t                side_s4;
	side_t                side_s5;
	logic [2*MAG_W-1:0]   sq_s5 [3];

	always_comb begin
		side_c4 = side_s3;
		for (int i = 0; i < 3; i++)
			side_c4.mag[i] = side_s3.mag[i] << lsh_s3;
	end

	// square root
	logic [SQ_W-1:0]     sq_x    [SQRT_STEPS+1];
	logic [SQ_REM_W-1:0] sq_rem  [SQRT_STEPS+1];
	logic [ROOT_W-1:0]   sq_root [SQRT_STEPS+1];
	side_t               sq_side [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3    <= '0;
			side_s4    <= '0;
			side_s5    <= '0;
			sq_side[0] <= '0;
		end else if (en) begin
			side_s3    <= side_c3;
			side_s4    <= side_c4;
			side_s5    <= side_s4;
			sq_side[0] <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lsh_s3 <= lsh_c;
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= side_s4.mag[i] * side_s4.mag[i];
			sq_x[0]    <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
		end
	end

	for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
		localparam int P = 2 * (SQRT_STEPS - 1 - t);
		logic [SQ_REM_W+1:0] tr;
		logic [SQ_REM_W+1:0] trial;

		always_comb begin
			tr    = {sq_rem[t], sq_x[t][P+1:P]};
			trial = {2'b00, sq_root[t], 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_side[t+1] <= '0;
			else if (en)
				sq_side[t+1] <= sq_side[t];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x[t+1] <= sq_x[t];
				if (tr >= trial) begin
					sq_rem[t+1]  <= SQ_REM_W'(tr - trial);
					sq_root[t+1] <= {sq_root[t][ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem[t+1]  <= tr[SQ_REM_W-1:0];
					sq_root[t+1] <= {sq_root[t][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// rounded division
	logic [DVD_W-1:0]     dv_d   [DIV_STEPS+1][3];
	logic [ROOT_W-1:0]    dv_rem [DIV_STEPS+1][3];
	logic [DIV_STEPS-1:0] dv_q   [DIV_STEPS+1][3];
	logic [ROOT_W-1:0]    dv_n   [DIV_STEPS+1];
	side_t                dv_side [DIV_STEPS+1];
	logic [DVD_W-1:0]     dvd_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dvd_c[i] = DVD_W'({sq_side[SQRT_STEPS].mag[i], {QB{1'b0}}}) +
				DVD_W'(sq_root[SQRT_STEPS] >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_side[0] <= '0;
		else if (en)
			dv_side[0] <= sq_side[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_n[0] <= sq_root[SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				dv_d[0][i]   <= dvd_c[i];
				dv_rem[0][i] <= ROOT_W'(dvd_c[i][DVD_W-1:DIV_STEPS]);
				dv_q[0][i]   <= '0;
			end
		end
	end

	for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
		localparam int B = DIV_STEPS - 1 - t;
		logic [ROOT_W:0] r2 [3];

		always_comb begin
			for (int i = 0; i < 3; i++)
				r2[i] = {dv_rem[t][i], dv_d[t][i][B]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_side[t+1] <= '0;
			else if (en)
				dv_side[t+1] <= dv_side[t];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_n[t+1] <= dv_n[t];
				for (int i = 0; i < 3; i++) begin
					dv_d[t+1][i] <= dv_d[t][i];
					if (r2[i] >= {1'b0, dv_n[t]}) begin
						dv_rem[t+1][i] <= ROOT_W'(r2[i] - {1'b0, dv_n[t]});
						dv_q[t+1][i]   <= {dv_q[t][i][DIV_STEPS-2:0], 1'b1};
					end else begin
						dv_rem[t+1][i] <= r2[i][ROOT_W-1:0];
						dv_q[t+1][i]   <= {dv_q[t][i][DIV_STEPS-2:0], 1'b0};
					end
				end
			end
		end
	end

	// sign and zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= dv_side[DIV_STEPS].vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_out <= dv_side[DIV_STEPS].zero;
			for (int i = 0; i < 3; i++) begin
				if (dv_side[DIV_STEPS].zero)
					u_out[i] <= '0;
				else if (dv_side[DIV_STEPS].sgn[i])
					u_out[i] <= -$signed(dv_q[DIV_STEPS][i]);
				else
					u_out[i] <= $signed(dv_q[DIV_STEPS][i]);
			end
		end
	end

endmodule

// ----- hdl/corot_trig.sv -----
// Pipelined sine and cosine of an angle in 1/64 degree units: range reduction,
// degree to radian scaling and an unrolled rotation CORDIC. Depends on corot_pkg.
module corot_trig (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             vld_in,
	input  logic signed [corot_pkg::AW-1:0]  angle,
	output logic                             vld_out,
	output logic signed [corot_pkg::CW-1:0]  cos_out,
	output logic signed [corot_pkg::CW-1:0]  sin_out
);
	import corot_pkg::*;

	localparam logic signed [AW:0] A_FULL = (AW+1)'(ANG_FULL);
	localparam logic signed [AW:0] A_HALF = (AW+1)'(ANG_HALF);
	localparam logic signed [AW:0] A_QTR  = (AW+1)'(ANG_QUARTER);

	// range reduction
	logic signed [AW:0]  a_c;
	logic                neg_c;
	logic [AMAG_W-1:0]   amag_s1;
	logic                asgn_s1;
	logic                neg_s1;
	logic                vld_s1;

	always_comb begin
		a_c   = (AW+1)'(angle);
		neg_c = 1'b0;
		if (a_c >= A_FULL)
			a_c = a_c - A_FULL;
		else if (a_c <= -A_FULL)
			a_c = a_c + A_FULL;
		if (a_c > A_HALF)
			a_c = a_c - A_FULL;
		else if (a_c < -A_HALF)
			a_c = a_c + A_FULL;
		if (a_c > A_QTR) begin
			a_c   = a_c - A_HALF;
			neg_c = 1'b1;
		end else if (a_c < -A_QTR) begin
			a_c   = a_c + A_HALF;
			neg_c = 1'b1;
		end
	end

	// radians = a * pi / 11520, split into quotient and remainder parts
	logic [31:0]               p1_s2;
	logic [25:0]               p2_s2;
	logic [31:0]               p1_s3;
	logic [36:0]               wm_s3;
	logic                      asgn_s2, asgn_s3;
	logic                      neg_s2, neg_s3;
	logic                      vld_s2, vld_s3;
	logic [17:0]               w_c;
	logic signed [CW-1:0]      zm_c;

	assign w_c  = 18'(p2_s2 >> PRE_SH);
	assign zm_c = $signed(CW'(p1_s3) + CW'(wm_s3 >> RECIP_SH));

	// CORDIC
	logic signed [CW-1:0] cx [TRIG_ITERATIONS+1];
	logic signed [CW-1:0] cy [TRIG_ITERATIONS+1];
	logic signed [CW-1:0] cz [TRIG_ITERATIONS+1];
	logic                 cneg [TRIG_ITERATIONS+1];
	logic                 cvld [TRIG_ITERATIONS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			cvld[0] <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			cvld[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amag_s1 <= a_c[AW] ? AMAG_W'(-a_c) : AMAG_W'(a_c);
			asgn_s1 <= a_c[AW];
			neg_s1  <= neg_c;
			p1_s2   <= 32'(amag_s1) * 32'(PI_QUO);
			p2_s2   <= 26'(amag_s1) * 26'(PI_REM);
			asgn_s2 <= asgn_s1;
			neg_s2  <= neg_s1;
			p1_s3   <= p1_s2;
			wm_s3   <= 37'(w_c) * 37'(RECIP45);
			asgn_s3 <= asgn_s2;
			neg_s3  <= neg_s2;
			cx[0]   <= CORDIC_GAIN;
			cy[0]   <= '0;
			cz[0]   <= asgn_s3 ? -zm_c : zm_c;
			cneg[0] <= neg_s3;
		end
	end

	for (genvar t = 0; t < TRIG_ITERATIONS; t++) begin : g_cordic
		logic signed [CW-1:0] at;
		assign at = $signed({2'b00, ATAN_Q30[t]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cvld[t+1] <= 1'b0;
			else if (en)
				cvld[t+1] <= cvld[t];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cneg[t+1] <= cneg[t];
				if (!cz[t][CW-1]) begin
					cx[t+1] <= cx[t] - (cy[t] >>> t);
					cy[t+1] <= cy[t] + (cx[t] >>> t);
					cz[t+1] <= cz[t] - at;
				end else begin
					cx[t+1] <= cx[t] + (cy[t] >>> t);
					cy[t+1] <= cy[t] - (cx[t] >>> t);
					cz[t+1] <= cz[t] + at;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= cvld[TRIG_ITERATIONS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= cneg[TRIG_ITERATIONS] ? -cx[TRIG_ITERATIONS] : cx[TRIG_ITERATIONS];
			sin_out <= cneg[TRIG_ITERATIONS] ? -cy[TRIG_ITERATIONS] : cy[TRIG_ITERATIONS];
		end
	end

endmodule

// ----- hdl/camera_orbit_rotation_core.sv -----
// Camera orbit rotation core: rotates eye and up about an axis-angle matrix.
// Depends on corot_pkg, corot_unitize and corot_trig.
//
// channel  | direction | tdata (low bit up)                   | tuser
// s_axis   | in        | angle, eye_x..eye_z, up_x..up_z      | mode
// m_axis   | out       | new_eye_x..new_eye_z, new_up_x..z    | degenerate
//
// One item per cycle while m_axis is not stalled; the two unit scaling
// pipelines compute one root bit and one quotient bit per stage. Reset
// clears the valid bits, the write pointer and corot_unitize side-band state.
// A stall at m_axis freezes the whole pipeline; nothing is dropped or repeated.
module camera_orbit_rotation_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [corot_pkg::IN_DW-1:0]       s_axis_tdata,  // angle, eye_x, eye_y, eye_z, up_x, up_y, up_z
	input  logic [0:0]                        s_axis_tuser,  // mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [corot_pkg::OUT_DW-1:0]      m_axis_tdata,  // new_eye_x..z, new_up_x..z
	output logic [0:0]                        m_axis_tuser   // degenerate
);
	import corot_pkg::*;

	localparam int TD     = UNIT_LAT - TRIG_LAT;
	localparam int EU_LEN = 2 * UNIT_LAT + 4;
	localparam int EU_W   = 6 * VW;
	localparam int PW     = 2 * VW;
	localparam int EW     = 34;
	localparam int MW     = 36;
	localparam int VPW    = UNIT_OW + VW;
	localparam int CS_AW  = 6;
	localparam int DG_AW  = 7;
	localparam int EU_AW  = 8;

	logic en;
	logic vld_s8;

	assign en            = !vld_s8 || m_axis_tready;
	assign s_axis_tready = en;

	// s1: inputs and cross product terms
	vec_t                 eye_c [3];
	vec_t                 up_c  [3];
	vec_t                 eye_s1 [3];
	vec_t                 up_s1  [3];
	logic signed [AW-1:0] angle_s1;
	logic                 mode_s1;
	logic                 vld_s1;
	logic signed [PW-1:0] pr_s1 [6];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_c[i] = s_axis_tdata[AW + VW*i +: VW];
			up_c[i]  = s_axis_tdata[AW + VW*(3+i) +: VW];
		end
	end

	// s2: raw axis
	logic signed [UW-1:0] raw_s2 [3];
	logic signed [AW-1:0] angle_s2;
	logic [EU_W-1:0]      eu_s2;
	logic                 vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1   <= eye_c;
			up_s1    <= up_c;
			angle_s1 <= s_axis_tdata[AW-1:0];
			mode_s1  <= s_axis_tuser[0];
			pr_s1[0] <= eye_c[1] * up_c[2];
			pr_s1[1] <= eye_c[2] * up_c[1];
			pr_s1[2] <= eye_c[2] * up_c[0];
			pr_s1[3] <= eye_c[0] * up_c[2];
			pr_s1[4] <= eye_c[0] * up_c[1];
			pr_s1[5] <= eye_c[1] * up_c[0];
			angle_s2 <= angle_s1;
			for (int i = 0; i < 3; i++) begin
				raw_s2[i] <= mode_s1 ? UW'(pr_s1[2*i]) - UW'(pr_s1[2*i+1]) : UW'(up_s1[i]);
				eu_s2[VW*i +: VW]     <= eye_s1[i];
				eu_s2[VW*(3+i) +: VW] <= up_s1[i];
			end
		end
	end

	// axis and angle
	logic                      ax_vld;
	logic                      ax_zero;
	logic signed [UNIT_OW-1:0] ax [3];
	logic                      trig_vld;
	logic signed [CW-1:0]      cos_v;
	logic signed [CW-1:0]      sin_v;

	corot_unitize u_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s2),
		.w_in     (raw_s2),
		.vld_out  (ax_vld),
		.zero_out (ax_zero),
		.u_out    (ax)
	);

	corot_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s2),
		.angle   (angle_s2),
		.vld_out (trig_vld),
		.cos_out (cos_v),
		.sin_out (sin_v)
	);

	// delay lines kept in memories, one write and one registered read per cycle while en is high
	logic [EU_AW-1:0] wp_q;
	logic [2*CW:0]    cs_mem [2**CS_AW];
	logic [2*CW:0]    cs_rd_q;
	logic [EU_W-1:0]  eu_mem [2**EU_AW];
	logic [EU_W-1:0]  eu_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wp_q <= '0;
		else if (en)
			wp_q <= wp_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_mem[wp_q[CS_AW-1:0]] <= {trig_vld, cos_v, sin_v};
			cs_rd_q <= cs_mem[CS_AW'(wp_q - EU_AW'(TD - 1))];
			eu_mem[wp_q] <= eu_s2;
			eu_rd_q <= eu_mem[wp_q - EU_AW'(EU_LEN - 1)];
		end
	end

	logic signed [CW-1:0] c_a;
	logic signed [CW-1:0] s_a;
	assign c_a = $signed(cs_rd_q[2*CW-1:CW]);
	assign s_a = $signed(cs_rd_q[CW-1:0]);

	// s3..s6: rotation matrix
	logic signed [2*UNIT_OW-1:0]    pp_s3 [6];
	logic signed [CW+UNIT_OW-1:0]   ps_s3 [3];
	logic signed [EW-1:0]           c_s3, oc_s3;
	logic signed [EW-1:0]           aa_s4 [6];
	logic signed [EW-1:0]           sa_s4 [3];
	logic signed [EW-1:0]           c_s4, oc_s4;
	logic signed [2*EW-1:0]         t_s5 [6];
	logic signed [EW-1:0]           sa_s5 [3];
	logic signed [EW-1:0]           c_s5;
	logic signed [MW-1:0]           rt_c [6];
	logic signed [MW-1:0]           sa_c [3];
	logic signed [MW-1:0]           c_c;
	logic signed [UW-1:0]           col_s6 [3][3];
	logic                           vld_s3, vld_s4, vld_s5, vld_s6;
	logic                           zero_s3, zero_s4, zero_s5, zero_s6;

	always_comb begin
		for (int i = 0; i < 6; i++)
			rt_c[i] = MW'((t_s5[i] + (68'sd1 <<< (QB - 1))) >>> QB);
		for (int i = 0; i < 3; i++)
			sa_c[i] = MW'(sa_s5[i]);
		c_c = MW'(c_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= ax_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s3[0] <= ax[0] * ax[0];
			pp_s3[1] <= ax[1] * ax[1];
			pp_s3[2] <= ax[2] * ax[2];
			pp_s3[3] <= ax[0] * ax[1];
			pp_s3[4] <= ax[0] * ax[2];
			pp_s3[5] <= ax[1] * ax[2];
			for (int i = 0; i < 3; i++)
				ps_s3[i] <= s_a * ax[i];
			c_s3    <= EW'(c_a);
			oc_s3   <= (EW'(1) <<< QB) - EW'(c_a);
			zero_s3 <= ax_zero;

			for (int i = 0; i < 6; i++)
				aa_s4[i] <= EW'((pp_s3[i] + (64'sd1 <<< (QB - 1))) >>> QB);
			for (int i = 0; i < 3; i++)
				sa_s4[i] <= EW'((ps_s3[i] + ((CW+UNIT_OW)'(1) <<< (QB - 1))) >>> QB);
			c_s4    <= c_s3;
			oc_s4   <= oc_s3;
			zero_s4 <= zero_s3;

			for (int i = 0; i < 6; i++)
				t_s5[i] <= oc_s4 * aa_s4[i];
			sa_s5   <= sa_s4;
			c_s5    <= c_s4;
			zero_s5 <= zero_s4;

			col_s6[0][0] <= UW'(c_c + rt_c[0]);
			col_s6[1][1] <= UW'(c_c + rt_c[1]);
			col_s6[2][2] <= UW'(c_c + rt_c[2]);
			col_s6[1][0] <= UW'(rt_c[3] - sa_c[2]);
			col_s6[0][1] <= UW'(rt_c[3] + sa_c[2]);
			col_s6[2][0] <= UW'(rt_c[4] + sa_c[1]);
			col_s6[0][2] <= UW'(rt_c[4] - sa_c[1]);
			col_s6[2][1] <= UW'(rt_c[5] - sa_c[0]);
			col_s6[1][2] <= UW'(rt_c[5] + sa_c[0]);
			zero_s6 <= zero_s5;
		end
	end

	// column scaling; col_s6[k] holds column k
	logic                      col_vld [3];
	logic                      col_zero [3];
	logic signed [UNIT_OW-1:0] ncol [3][3];

	for (genvar k = 0; k < 3; k++) begin : g_col
		corot_unitize u_col (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld_s6),
			.w_in     (col_s6[k]),
			.vld_out  (col_vld[k]),
			.zero_out (col_zero[k]),
			.u_out    (ncol[k])
		);
	end

	logic dg_mem [2**DG_AW];
	logic dg_rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dg_mem[wp_q[DG_AW-1:0]] <= zero_s6;
			dg_rd_q <= dg_mem[DG_AW'(wp_q - EU_AW'(UNIT_LAT - 1))];
		end
	end

	// s7, s8: matrix times vectors, round, saturate
	vec_t                  eye_d [3];
	vec_t                  up_d  [3];
	logic signed [VPW-1:0] pe_s7 [3][3];
	logic signed [VPW-1:0] pu_s7 [3][3];
	logic [EU_W-1:0]       eu_s7;
	logic                  deg_s7;
	logic                  vld_s7;
	logic [OUT_DW-1:0]     out_s8;
	logic                  deg_s8;
	logic signed [VPW+1:0] se_c [3];
	logic signed [VPW+1:0] su_c [3];
	vec_t                  re_c [3];
	vec_t                  ru_c [3];

	always_comb begin
		logic signed [VPW+1-QB:0] v;
		for (int i = 0; i < 3; i++) begin
			eye_d[i] = eu_rd_q[VW*i +: VW];
			up_d[i]  = eu_rd_q[VW*(3+i) +: VW];
		end
		for (int r = 0; r < 3; r++) begin
			se_c[r] = (VPW+2)'(pe_s7[r][0]) + (VPW+2)'(pe_s7[r][1]) + (VPW+2)'(pe_s7[r][2]);
			su_c[r] = (VPW+2)'(pu_s7[r][0]) + (VPW+2)'(pu_s7[r][1]) + (VPW+2)'(pu_s7[r][2]);
			v = (VPW+2-QB)'((se_c[r] + ((VPW+2)'(1) <<< (QB - 1))) >>> QB);
			if (v > (VPW+2-QB)'(OUT_MAX))
				re_c[r] = OUT_MAX;
			else if (v < (VPW+2-QB)'(OUT_MIN))
				re_c[r] = OUT_MIN;
			else
				re_c[r] = VW'(v);
			v = (VPW+2-QB)'((su_c[r] + ((VPW+2)'(1) <<< (QB - 1))) >>> QB);
			if (v > (VPW+2-QB)'(OUT_MAX))
				ru_c[r] = OUT_MAX;
			else if (v < (VPW+2-QB)'(OUT_MIN))
				ru_c[r] = OUT_MIN;
			else
				ru_c[r] = VW'(v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s7 <= col_vld[0];
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++) begin
					pe_s7[r][k] <= ncol[k][r] * eye_d[k];
					pu_s7[r][k] <= ncol[k][r] * up_d[k];
				end
			eu_s7  <= eu_rd_q;
			deg_s7 <= dg_rd_q | (col_zero[0] & col_zero[1] & col_zero[2] & 1'b0);
			deg_s8 <= deg_s7;
			if (deg_s7)
				out_s8 <= eu_s7;
			else
				for (int r = 0; r < 3; r++) begin
					out_s8[VW*r +: VW]     <= re_c[r];
					out_s8[VW*(3+r) +: VW] <= ru_c[r];
				end
		end
	end

	assign m_axis_tvalid   = vld_s8;
	assign m_axis_tdata    = out_s8;
	assign m_axis_tuser[0] = deg_s8;

endmodule

// ----- test/tb.sv -----
// Testbench for camera_orbit_rotation_core: directed and random camera updates,
// checked against a bit-exact axis-angle rotation predictor. Depends on corot_pkg.
module tb;
	import corot_pkg::*;

	typedef longint trip_t [3];
	typedef struct {
		logic [VW-1:0] fld [6];
		logic          deg;
	} rot_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_DW-1:0]    s_axis_tdata = '0;
	logic [0:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_DW-1:0]   m_axis_tdata;
	logic [0:0]          m_axis_tuser;

	rot_result_t rot_queue [$];
	int          n_bad = 0;
	int          idle_cycles = 0;
	bit          quiet_phase = 0;

	camera_orbit_rotation_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic longint unsigned magv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned max_mag3(trip_t w);
		longint unsigned m;
		m = magv(w[0]);
		if (magv(w[1]) > m) m = magv(w[1]);
		if (magv(w[2]) > m) m = magv(w[2]);
		return m;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic bit make_unit(trip_t v, output trip_t u);
		trip_t w;
		longint unsigned ss, n, q;
		w = v;
		u = '{0, 0, 0};
		if (max_mag3(w) == 0) return 0;
		while (max_mag3(w) >= (64'd1 << QB))
			for (int i = 0; i < 3; i++) w[i] = w[i] >>> 1;
		while (max_mag3(w) < (64'd1 << (QB - 1)))
			for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
		ss = 0;
		for (int i = 0; i < 3; i++) ss += magv(w[i]) * magv(w[i]);
		n = int_sqrt(ss);
		for (int i = 0; i < 3; i++) begin
			q = ((magv(w[i]) << QB) + n / 2) / n;
			u[i] = w[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void angle_trig(longint ang, output longint s, output longint c);
		longint a, x, y, z, nx;
		bit flip;
		a = ang % ANG_FULL;
		flip = 0;
		x = 652032874;
		y = 0;
		if (a > ANG_HALF) a -= ANG_FULL;
		if (a < -ANG_HALF) a += ANG_FULL;
		if (a > ANG_QUARTER) begin
			a -= ANG_HALF;
			flip = 1;
		end else if (a < -ANG_QUARTER) begin
			a += ANG_HALF;
			flip = 1;
		end
		z = (a * 64'sd3373259426) / ANG_HALF;
		for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_Q30[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_Q30[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic rot_result_t rotate_camera(bit mode, logic [IN_DW-1:0] d);
		rot_result_t res;
		trip_t eye, up, raw, ax, col, ncol;
		longint m [3][3];
		longint s, c, oc, se, su;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'($signed(d[AW + i*VW +: VW]));
			up[i]  = longint'($signed(d[AW + (3+i)*VW +: VW]));
		end
		if (!mode) begin
			raw = up;
		end else begin
			raw[0] = eye[1] * up[2] - eye[2] * up[1];
			raw[1] = eye[2] * up[0] - eye[0] * up[2];
			raw[2] = eye[0] * up[1] - eye[1] * up[0];
		end
		if (!make_unit(raw, ax)) begin
			for (int i = 0; i < 3; i++) begin
				res.fld[i] = eye[i][VW-1:0];
				res.fld[3+i] = up[i][VW-1:0];
			end
			res.deg = 1'b1;
			return res;
		end
		angle_trig(longint'($signed(d[AW-1:0])), s, c);
		oc = (64'sd1 <<< QB) - c;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				m[r][k] = (r == k ? c : 0) + round_sh(oc * round_sh(ax[r] * ax[k], QB), QB);
		m[1][0] += round_sh(s * ax[2], QB);
		m[2][0] -= round_sh(s * ax[1], QB);
		m[0][1] -= round_sh(s * ax[2], QB);
		m[2][1] += round_sh(s * ax[0], QB);
		m[0][2] += round_sh(s * ax[1], QB);
		m[1][2] -= round_sh(s * ax[0], QB);
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) col[r] = m[r][k];
			void'(make_unit(col, ncol));
			for (int r = 0; r < 3; r++) m[r][k] = ncol[r];
		end
		for (int r = 0; r < 3; r++) begin
			se = 0;
			su = 0;
			for (int k = 0; k < 3; k++) begin
				se += m[r][k] * eye[k];
				su += m[r][k] * up[k];
			end
			res.fld[r] = VW'(clamp24(round_sh(se, QB)));
			res.fld[3+r] = VW'(clamp24(round_sh(su, QB)));
		end
		res.deg = 1'b0;
		return res;
	endfunction

	// ---------------- stimulus ----------------
	function automatic int gap_len();
		if (quiet_phase) return 0;
		case ($urandom_range(0, 19))
			0: return $urandom_range(10, 40);
			1, 2, 3, 4, 5: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	task automatic send_camera(bit mode, logic signed [AW-1:0] ang,
			logic signed [VW-1:0] e0, e1, e2, u0, u1, u2);
		int g;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = mode;
		s_axis_tdata = {u2, u1, u0, e2, e1, e0, ang};
		do @(posedge clk); while (!s_axis_tready);
		rot_queue.push_back(rotate_camera(mode, s_axis_tdata));
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (quiet_phase) m_axis_tready = 1'b1;
		else if ($urandom_range(0, 299) == 0) m_axis_tready = 1'b0;
		else if (!m_axis_tready) m_axis_tready = $urandom_range(0, 5) == 0;
		else m_axis_tready = $urandom_range(0, 5) != 0;
	end

	function automatic logic signed [VW-1:0] rand_comp();
		logic signed [VW-1:0] r;
		r = VW'($urandom);
		if ($urandom_range(0, 2) == 0) return r;
		return r >>> $urandom_range(0, VW - 1);
	endfunction

	task automatic test_directed();
		send_camera(0, 0, 65536, 0, 0, 0, 65536, 0);
		send_camera(0, 90*64, 65536, 0, 0, 0, 65536, 0);
		send_camera(0, -90*64, 65536, 0, 0, 0, 65536, 0);
		send_camera(0, 180*64, 65536, 2, 3, 0, 0, 65536);
		send_camera(1, 45*64, 0, 0, 65536, 0, 65536, 0);
		send_camera(1, 16'sh7FFF, 0, 0, 65536, 0, 65536, 0);
		send_camera(1, 16'sh8000, 0, 0, 65536, 65536, 0, 0);
		send_camera(0, 30*64, 1, -1, 2, 0, 0, 0);
		send_camera(1, 30*64, 1000, 2000, 3000, 2000, 4000, 6000);
		send_camera(1, 30*64, 0, 0, 0, 5, 6, 7);
		send_camera(0, 45*64, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 1);
		send_camera(0, -45*64, 24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 1);
		send_camera(1, 17*64, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
			24'sh800000, 24'sh7FFFFF, 24'sh800000);
		send_camera(0, 270*64, 24'sh800000, 0, 0, 1, 1, 1);
		send_camera(0, 360*64 + 1, 123456, -654321, 1, 0, 0, -1);
		send_camera(1, -1, 1, 0, 0, 0, 1, 0);
		send_camera(0, 16'sh7FFF, 24'sh7FFFFF, 0, 24'sh800000, 24'sh800000, 0, 0);
		send_camera(1, 100*64, 24'sh400000, -24'sh400000, 1, 24'sh7FFFFF, 1, 24'sh800000);
	endtask

	task automatic test_random(int count);
		logic signed [VW-1:0] e0, e1, e2, u0, u1, u2;
		bit mode;
		int k;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 0) quiet_phase = $urandom_range(0, 3) == 0;
			mode = 1'($urandom);
			e0 = rand_comp(); e1 = rand_comp(); e2 = rand_comp();
			u0 = rand_comp(); u1 = rand_comp(); u2 = rand_comp();
			case ($urandom_range(0, 29))
				0: begin
					u0 = 0; u1 = 0; u2 = 0;
				end
				1: begin
					k = int'($urandom_range(0, 6)) - 3;
					e0 = e0 >>> 3; e1 = e1 >>> 3; e2 = e2 >>> 3;
					u0 = VW'(e0 * k); u1 = VW'(e1 * k); u2 = VW'(e2 * k);
				end
				2: begin
					e0 = 0; e1 = 0; e2 = 0;
				end
				default: ;
			endcase
			send_camera(mode, AW'($urandom), e0, e1, e2, u0, u1, u2);
		end
		quiet_phase = 0;
	endtask

	// ---------------- checking ----------------
	always @(posedge clk) begin
		rot_result_t exp_r;
		logic [VW-1:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rot_queue.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_r = rot_queue.pop_front();
				for (int i = 0; i < 6; i++) begin
					got = m_axis_tdata[i*VW +: VW];
					if (got !== exp_r.fld[i]) begin
						n_bad++;
						if (n_bad <= 10)
							$display("field %0d: expected %h got %h", i, exp_r.fld[i], got);
					end
				end
				if (m_axis_tuser[0] !== exp_r.deg) begin
					n_bad++;
					if (n_bad <= 10)
						$display("degenerate: expected %b got %b", exp_r.deg, m_axis_tuser[0]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(1250);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (rot_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_bad == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
